// File: rtl/core/sff_pkg.sv
// shared types, codes and constants of the slot frame fifo
// no dependencies

package sff_pkg;

  localparam int RING_SLOTS_DEF = 32;
  localparam int SLOT_BYTES_DEF = 2048;

  localparam int CMD_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int TS_W      = 33;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_OUT_W = 6;
  localparam int SUM_OUT_W = 17;

  localparam logic [CFG_W-1:0] CHUNK_LIMIT_RST = 12'd2048;
  localparam logic [CFG_W-1:0] READ_LIMIT_RST  = 12'd2048;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DROP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT  = 2'd1;

  typedef enum logic [5:0] {
    OP_PUSH  = 6'b000001,
    OP_READ  = 6'b000010,
    OP_DROP  = 6'b000100,
    OP_FLUSH = 6'b001000,
    OP_QUERY = 6'b010000,
    OP_NONE  = 6'b100000
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data_byte;
    logic [TS_W-1:0]   timestamp;
    logic              timestamp_valid;
    logic              end_of_message;
  } sff_item_t;

  typedef struct packed {
    status_t              status;
    logic [BYTE_W-1:0]    data_byte;
    logic                 byte_valid;
    logic                 last_of_slot;
    logic [TS_W-1:0]      timestamp;
    logic                 timestamp_valid;
    logic [CNT_OUT_W-1:0] slots_filled;
    logic [CNT_OUT_W-1:0] slots_free;
    logic [SUM_OUT_W-1:0] bytes_filled;
  } sff_result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } sff_cfg_t;

endpackage

// File: rtl/core/sff_front.sv
// front end: takes command items and decodes them into operations
// depends on sff_pkg

module sff_front (
  input  logic                     valid,
  output logic                     stall,
  input  logic [sff_pkg::CMD_W-1:0] command,
  input  logic [sff_pkg::BYTE_W-1:0] data_byte,
  input  logic [sff_pkg::TS_W-1:0] timestamp,
  input  logic                     timestamp_valid,
  input  logic                     end_of_message,
  output logic                     push_valid,
  input  logic                     push_stall,
  output sff_pkg::sff_item_t       push_item
);
  import sff_pkg::*;

  op_t op;

  always_comb begin
    unique case (command)
      CMD_PUSH:  op = OP_PUSH;
      CMD_READ:  op = OP_READ;
      CMD_DROP:  op = OP_DROP;
      CMD_FLUSH: op = OP_FLUSH;
      CMD_QUERY: op = OP_QUERY;
      default:   op = OP_NONE;
    endcase
  end

  always_comb begin
    push_item.op              = op;
    push_item.data_byte       = data_byte;
    push_item.timestamp       = timestamp;
    push_item.timestamp_valid = timestamp_valid;
    push_item.end_of_message  = end_of_message;
  end

  assign push_valid = valid;
  assign stall      = push_stall;

endmodule

// File: rtl/core/sff_queue.sv
// two-entry queue of decoded items between front and back end
// depends on sff_pkg

module sff_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_stall,
  input  sff_pkg::sff_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output sff_pkg::sff_item_t pop_item
);
  import sff_pkg::*;

  sff_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entry[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");

endmodule

// File: rtl/core/sff_back.sv
// back end: slot store, head slot bookkeeping, running counts and result register
// depends on sff_pkg

module sff_back #(
  parameter int RING_SLOTS = sff_pkg::RING_SLOTS_DEF,
  parameter int SLOT_BYTES = sff_pkg::SLOT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sff_pkg::sff_cfg_t   cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  sff_pkg::sff_item_t  item,
  output logic                res_valid,
  input  logic                res_stall,
  output sff_pkg::sff_result_t res
);
  import sff_pkg::*;

  localparam int SLOT_W      = $clog2(RING_SLOTS);
  localparam int CNT_W       = $clog2(RING_SLOTS + 1);
  localparam int OFF_W       = $clog2(SLOT_BYTES + 1);
  localparam int STORE_DEPTH = RING_SLOTS * SLOT_BYTES;
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int SUM_W       = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W       = ((OFF_W > CFG_W) ? OFF_W : CFG_W) + 1;
  localparam int TIME_W      = TS_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_t;

  state_t state;

  logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
  logic [OFF_W-1:0]  len_mem   [RING_SLOTS];
  logic [TIME_W-1:0] time_mem  [RING_SLOTS];

  logic [BYTE_W-1:0] store_q;
  logic [OFF_W-1:0]  len_q;
  logic [TIME_W-1:0] time_q;

  logic [CFG_W-1:0]  chunk_limit;
  logic [CFG_W-1:0]  read_limit;

  sff_item_t         cur;

  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [OFF_W-1:0]  write_offset, write_offset_next;
  logic              write_open, write_open_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic [OFF_W-1:0]  read_offset, read_offset_next;
  logic [CNT_W-1:0]  filled_count, filled_count_next;
  logic [SUM_W-1:0]  byte_sum, byte_sum_next;

  logic              start;
  logic              fire;
  logic              store_we;
  logic              len_we;
  logic              time_we;
  logic [SA_W-1:0]   wr_addr;
  logic [SA_W-1:0]   rd_addr;

  logic [CMP_W-1:0]  slot_bytes_c;
  logic [CMP_W-1:0]  chunk_ext;
  logic [CMP_W-1:0]  limit;
  logic [CMP_W-1:0]  new_off;
  logic [CMP_W-1:0]  head_n;
  logic [CMP_W-1:0]  ro_ext;
  logic [CMP_W-1:0]  ro_inc;
  logic              is_empty;
  logic              is_full;
  logic              do_free;

  status_t           r_status;
  logic              r_bv;
  logic              r_last;
  logic              r_tsv;
  logic [TS_W-1:0]   r_ts;
  logic [31:0]       free_calc;
  logic [31:0]       filled_wide;
  logic [31:0]       sum_wide;

  assign item_ready = (state == ST_IDLE);
  assign start      = item_ready && item_valid;
  assign fire       = (state == ST_WORK) && (!res_valid || !res_stall);

  assign wr_addr = SA_W'(write_slot) * SA_W'(SLOT_BYTES) + SA_W'(write_offset);
  assign rd_addr = SA_W'(read_slot) * SA_W'(SLOT_BYTES) + SA_W'(read_offset);

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      store_mem[wr_addr] <= cur.data_byte;
    end
    if (start) begin
      store_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && len_we) begin
      len_mem[write_slot] <= OFF_W'(new_off);
    end
    if (start) begin
      len_q <= len_mem[read_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && time_we) begin
      time_mem[write_slot] <= {cur.timestamp_valid, cur.timestamp};
    end
    if (start) begin
      time_q <= time_mem[read_slot];
    end
  end

  always_comb begin
    slot_bytes_c = CMP_W'(SLOT_BYTES);
    chunk_ext    = CMP_W'(chunk_limit);
    if (chunk_ext == '0) begin
      limit = CMP_W'(1);
    end else if (chunk_ext > slot_bytes_c) begin
      limit = slot_bytes_c;
    end else begin
      limit = chunk_ext;
    end
    new_off = CMP_W'(write_offset) +
              ((CMP_W'(write_offset) < slot_bytes_c) ? CMP_W'(1) : CMP_W'(0));
    head_n  = (CMP_W'(len_q) < CMP_W'(read_limit)) ? CMP_W'(len_q) : CMP_W'(read_limit);
    ro_ext  = CMP_W'(read_offset);
    ro_inc  = ro_ext + CMP_W'(1);
    is_empty = (filled_count == '0);
    is_full  = !write_open && (filled_count >= CNT_W'(RING_SLOTS));
  end

  always_comb begin
    write_slot_next   = write_slot;
    write_offset_next = write_offset;
    write_open_next   = write_open;
    read_slot_next    = read_slot;
    read_offset_next  = read_offset;
    filled_count_next = filled_count;
    byte_sum_next     = byte_sum;
    store_we          = 1'b0;
    len_we            = 1'b0;
    time_we           = 1'b0;
    do_free           = 1'b0;
    r_status          = STATUS_OK;
    r_bv              = 1'b0;
    r_last            = 1'b0;
    r_tsv             = 1'b0;
    r_ts              = '0;

    unique case (cur.op)
      OP_PUSH: begin
        if (is_full) begin
          r_status = STATUS_FULL;
        end else begin
          time_we  = !write_open;
          store_we = (CMP_W'(write_offset) < slot_bytes_c);
          if (new_off >= limit || cur.end_of_message) begin
            len_we            = 1'b1;
            byte_sum_next     = byte_sum + SUM_W'(new_off);
            filled_count_next = filled_count + CNT_W'(1);
            write_slot_next   = (write_slot == SLOT_W'(RING_SLOTS - 1)) ?
                                '0 : write_slot + SLOT_W'(1);
            write_open_next   = 1'b0;
            write_offset_next = '0;
          end else begin
            write_open_next   = 1'b1;
            write_offset_next = OFF_W'(new_off);
          end
        end
      end
      OP_READ: begin
        if (is_empty) begin
          r_status = STATUS_EMPTY;
        end else begin
          r_ts  = time_q[TS_W-1:0];
          r_tsv = time_q[TS_W];
          if (ro_ext >= head_n || ro_ext >= slot_bytes_c) begin
            r_last  = 1'b1;
            do_free = 1'b1;
          end else begin
            r_bv = 1'b1;
            if (ro_inc >= head_n) begin
              r_last  = 1'b1;
              do_free = 1'b1;
            end else begin
              read_offset_next = OFF_W'(ro_inc);
            end
          end
        end
      end
      OP_DROP: begin
        if (is_empty) begin
          r_status = STATUS_EMPTY;
        end else begin
          do_free = 1'b1;
        end
      end
      OP_FLUSH: begin
        write_slot_next   = '0;
        write_offset_next = '0;
        write_open_next   = 1'b0;
        read_slot_next    = '0;
        read_offset_next  = '0;
        filled_count_next = '0;
        byte_sum_next     = '0;
      end
      OP_QUERY: begin
        if (is_empty) begin
          r_status = STATUS_EMPTY;
        end else begin
          r_ts  = time_q[TS_W-1:0];
          r_tsv = time_q[TS_W];
        end
      end
      default: begin
      end
    endcase

    if (do_free) begin
      byte_sum_next     = byte_sum - SUM_W'(len_q);
      filled_count_next = filled_count - CNT_W'(1);
      read_slot_next    = (read_slot == SLOT_W'(RING_SLOTS - 1)) ?
                          '0 : read_slot + SLOT_W'(1);
      read_offset_next  = '0;
    end

    filled_wide = 32'(filled_count_next);
    sum_wide    = 32'(byte_sum_next);
    free_calc   = 32'(RING_SLOTS) - filled_wide - 32'(write_open_next);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= item;
    end
    if (fire) begin
      res.status          <= r_status;
      res.data_byte       <= r_bv ? store_q : '0;
      res.byte_valid      <= r_bv;
      res.last_of_slot    <= r_last;
      res.timestamp       <= r_ts;
      res.timestamp_valid <= r_tsv;
      res.slots_filled    <= filled_wide[CNT_OUT_W-1:0];
      res.slots_free      <= free_calc[CNT_OUT_W-1:0];
      res.bytes_filled    <= sum_wide[SUM_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      res_valid    <= 1'b0;
      chunk_limit  <= CHUNK_LIMIT_RST;
      read_limit   <= READ_LIMIT_RST;
      write_slot   <= '0;
      write_offset <= '0;
      write_open   <= 1'b0;
      read_slot    <= '0;
      read_offset  <= '0;
      filled_count <= '0;
      byte_sum     <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          REG_CHUNK_LIMIT: chunk_limit <= cfg.data;
          REG_READ_LIMIT:  read_limit  <= cfg.data;
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fire) begin
        res_valid    <= 1'b1;
        write_slot   <= write_slot_next;
        write_offset <= write_offset_next;
        write_open   <= write_open_next;
        read_slot    <= read_slot_next;
        read_offset  <= read_offset_next;
        filled_count <= filled_count_next;
        byte_sum     <= byte_sum_next;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    filled_count <= CNT_W'(RING_SLOTS))
    else $error("filled slot count above ring size");

  assert property (@(posedge clk) disable iff (rst)
    write_open |-> (filled_count < CNT_W'(RING_SLOTS)))
    else $error("open write slot while ring is full");

  assert property (@(posedge clk) disable iff (rst)
    (filled_count == '0) |-> (byte_sum == '0))
    else $error("byte count left over with no filled slot");

  assert property (@(posedge clk) disable iff (rst)
    fire |=> (res_valid && state == ST_IDLE))
    else $error("finished item did not reach result register");

endmodule

// File: rtl/core/slot_frame_fifo_top.sv
// slot frame fifo: ring of fixed-size slots holding timestamped byte chunks
// instantiates sff_front, sff_queue and sff_back; depends on sff_pkg
//
// Usage:
//   command channel (cmd_valid / cmd_stall) carries command, data_byte,
//   timestamp, timestamp_valid and end_of_message; an item is taken at an
//   edge with cmd_valid high and cmd_stall low.
//   result channel (res_valid / res_stall) returns exactly one result per
//   command: status, read byte, slot flags, head timestamp and the counts.
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   chunk_limit (index 0) and read_limit (index 1); cfg_ready is always high.
// Flow:
//   a command is decoded and queued in a two-entry queue; the back end first
//   does the registered read of the head slot memories, then updates the
//   pointers and loads the result register, waiting there while the result
//   stalls; it takes no new command until that result is loaded.
// Reset (rst, synchronous): all slots free, pointers at slot 0, both limits
//   2048; slot memories are not cleared, only written entries are read.
// A stalled result holds; the back end waits and the queue then fills and
//   raises cmd_stall.

module slot_frame_fifo_top #(
  parameter int RING_SLOTS = sff_pkg::RING_SLOTS_DEF,
  parameter int SLOT_BYTES = sff_pkg::SLOT_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sff_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [sff_pkg::CMD_W-1:0]     command,
  input  logic [sff_pkg::BYTE_W-1:0]    data_byte,
  input  logic [sff_pkg::TS_W-1:0]      timestamp,
  input  logic                          timestamp_valid,
  input  logic                          end_of_message,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [1:0]                    status,
  output logic [sff_pkg::BYTE_W-1:0]    data_byte_res,
  output logic                          byte_valid,
  output logic                          last_of_slot,
  output logic [sff_pkg::TS_W-1:0]      timestamp_res,
  output logic                          timestamp_valid_res,
  output logic [sff_pkg::CNT_OUT_W-1:0] slots_filled,
  output logic [sff_pkg::CNT_OUT_W-1:0] slots_free,
  output logic [sff_pkg::SUM_OUT_W-1:0] bytes_filled
);
  import sff_pkg::*;

  sff_item_t   push_item;
  sff_item_t   pop_item;
  logic        push_valid;
  logic        push_stall;
  logic        pop_valid;
  logic        pop_ready;
  sff_cfg_t    cfg;
  sff_result_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.we    = cfg_valid && cfg_ready;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  sff_front u_front (
    .valid           (cmd_valid),
    .stall           (cmd_stall),
    .command         (command),
    .data_byte       (data_byte),
    .timestamp       (timestamp),
    .timestamp_valid (timestamp_valid),
    .end_of_message  (end_of_message),
    .push_valid      (push_valid),
    .push_stall      (push_stall),
    .push_item       (push_item)
  );

  sff_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sff_back #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  assign status              = res.status;
  assign data_byte_res       = res.data_byte;
  assign byte_valid          = res.byte_valid;
  assign last_of_slot        = res.last_of_slot;
  assign timestamp_res       = res.timestamp;
  assign timestamp_valid_res = res.timestamp_valid;
  assign slots_filled        = res.slots_filled;
  assign slots_free          = res.slots_free;
  assign bytes_filled        = res.bytes_filled;

endmodule
